// File: design/wld_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wld_pkg
// Shared constants for the wavelet low-pass decimator: default widths,
// mode codes and the Daubechies-2 low-pass coefficients.
// ----------------------------------------------------------------------------
package wld_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int TIME_BITS_DEF   = 32;

  localparam int MODE_W = 2;
  localparam logic [MODE_W-1:0] MODE_HAAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_D4   = 2'd1;

  localparam int NUM_TAPS    = 4;
  localparam int COEF_W      = 17;
  localparam int ROUND_SHIFT = 14;

  // Q0.16 coefficients ordered from the newest sample to the oldest.
  localparam logic signed [COEF_W-1:0] D4_COEF [NUM_TAPS] = '{
    -17'sd8481, 17'sd14689, 17'sd54822, 17'sd31652
  };

endpackage

// File: design/wld_tap_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wld_tap_cell
// One cell of the sample history chain. On each shift it takes the sample
// and timestamp from its neighbor, keeps them, and registers the product of
// the incoming sample with its filter coefficient.
// ----------------------------------------------------------------------------
module wld_tap_cell
  import wld_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  shift_en,
  input  logic signed [COEF_W-1:0]              coef,
  input  logic        [SAMPLE_BITS-1:0]         sample_in,
  input  logic        [TIME_BITS-1:0]           time_in,
  output logic        [SAMPLE_BITS-1:0]         sample_q,
  output logic        [TIME_BITS-1:0]           time_q,
  output logic signed [SAMPLE_BITS+COEF_W-1:0]  prod_q
);

  localparam int PROD_W = SAMPLE_BITS + COEF_W;

  logic        [SAMPLE_BITS-1:0] sample_r;
  logic        [TIME_BITS-1:0]   time_r;
  logic signed [PROD_W-1:0]      prod_r;
  logic signed [PROD_W-1:0]      prod_nxt;

  assign prod_nxt = PROD_W'($signed({1'b0, sample_in})) * PROD_W'(coef);

  always_ff @(posedge clk) begin
    if (shift_en) begin
      sample_r <= sample_in;
      time_r   <= time_in;
      prod_r   <= prod_nxt;
    end
  end

  assign sample_q = sample_r;
  assign time_q   = time_r;
  assign prod_q   = prod_r;

endmodule

// File: design/wavelet_lowpass_decimator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavelet_lowpass_decimator
// Haar / Daubechies-2 low-pass decimator with passthrough for a stream of
// state-of-charge samples and their timestamps.
// ----------------------------------------------------------------------------
// The block accepts one input word per clock cycle unless a stalled output
// holds the tap stage full. Each accepted word is first shifted into a chain
// of four tap cells that each multiply their new sample by one filter
// coefficient and register the product; the taps are then added, rounded,
// and loaded into the output register. Haar mode emits one word per pair,
// Daubechies-2 one word per stride of two after four samples, passthrough one
// word per sample. A write to the mode register restarts the window.
module wavelet_lowpass_decimator
  import wld_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [MODE_W-1:0]      cfg_data,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // soc_sample, sample_time, zero fill
  input  logic [((SAMPLE_BITS+TIME_BITS+7)/8)*8-1:0] in_tdata,
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // avg_soc, avg_time, zero fill
  output logic [((SAMPLE_BITS+TIME_BITS+6+7)/8)*8-1:0] out_tdata,
  output logic                   out_tlast
);

  localparam int OUT_W      = ((SAMPLE_BITS + TIME_BITS + 6 + 7) / 8) * 8;
  localparam int SOC_OUT_W  = SAMPLE_BITS + 4;
  localparam int TIME_OUT_W = TIME_BITS + 2;
  localparam int PROD_W     = SAMPLE_BITS + COEF_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam logic signed [ACC_W-1:0] ROUND_ADD = ACC_W'(1 << (ROUND_SHIFT - 1));

  typedef enum logic [1:0] {
    KIND_HAAR,
    KIND_D4,
    KIND_PASS
  } kind_t;

  logic [MODE_W-1:0] mode_r;
  logic [1:0]        pos_r;
  logic [1:0]        pos_nxt;
  logic              emit_nxt;
  kind_t             kind_nxt;

  logic  a_valid_r;
  kind_t a_kind_r;
  logic  a_last_r;

  logic                  out_valid_r;
  logic [SOC_OUT_W-1:0]  out_soc_r;
  logic [TIME_OUT_W-1:0] out_time_r;
  logic                  out_last_r;

  logic in_fire;
  logic cfg_fire;
  logic out_free;

  logic        [SAMPLE_BITS-1:0] tap_sample [NUM_TAPS];
  logic        [TIME_BITS-1:0]   tap_time   [NUM_TAPS];
  logic signed [PROD_W-1:0]      tap_prod   [NUM_TAPS];

  logic        [SAMPLE_BITS-1:0] in_soc;
  logic        [TIME_BITS-1:0]   in_time;

  logic signed [ACC_W-1:0]       acc;
  logic signed [ACC_W-1:0]       acc_rnd;
  logic        [SAMPLE_BITS:0]   haar_soc_sum;
  logic        [TIME_BITS:0]     haar_time_sum;
  logic        [TIME_OUT_W-1:0]  d4_time_sum;
  logic        [SOC_OUT_W-1:0]   soc_nxt;
  logic        [TIME_OUT_W-1:0]  time_nxt;

  assign in_soc  = in_tdata[SAMPLE_BITS-1:0];
  assign in_time = in_tdata[SAMPLE_BITS +: TIME_BITS];

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !a_valid_r || out_free;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // History chain: the newest sample enters cell 0.
  for (genvar k = 0; k < NUM_TAPS; k++) begin : g_tap
    logic [SAMPLE_BITS-1:0] s_in;
    logic [TIME_BITS-1:0]   t_in;
    if (k == 0) begin : g_head
      assign s_in = in_soc;
      assign t_in = in_time;
    end else begin : g_link
      assign s_in = tap_sample[k-1];
      assign t_in = tap_time[k-1];
    end
    wld_tap_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .TIME_BITS   (TIME_BITS)
    ) u_cell (
      .clk       (clk),
      .shift_en  (in_fire),
      .coef      (D4_COEF[k]),
      .sample_in (s_in),
      .time_in   (t_in),
      .sample_q  (tap_sample[k]),
      .time_q    (tap_time[k]),
      .prod_q    (tap_prod[k])
    );
  end

  always_comb begin
    pos_nxt  = pos_r;
    emit_nxt = 1'b0;
    kind_nxt = KIND_PASS;
    unique case (mode_r)
      MODE_HAAR: begin
        kind_nxt = KIND_HAAR;
        if (pos_r == 2'd0) begin
          pos_nxt = 2'd1;
        end else begin
          emit_nxt = 1'b1;
          pos_nxt  = 2'd0;
        end
      end
      MODE_D4: begin
        kind_nxt = KIND_D4;
        if (pos_r == 2'd3) begin
          emit_nxt = 1'b1;
          pos_nxt  = 2'd2;
        end else begin
          pos_nxt = pos_r + 2'd1;
        end
      end
      default: begin
        emit_nxt = 1'b1;
        pos_nxt  = 2'd0;
      end
    endcase
    if (in_tlast) begin
      pos_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_HAAR;
      pos_r     <= 2'd0;
      a_valid_r <= 1'b0;
      a_kind_r  <= KIND_HAAR;
      a_last_r  <= 1'b0;
    end else begin
      if (cfg_fire) begin
        mode_r <= cfg_data;
        pos_r  <= 2'd0;
      end else if (in_fire) begin
        pos_r <= pos_nxt;
      end
      if (in_fire) begin
        a_valid_r <= emit_nxt;
        a_kind_r  <= kind_nxt;
        a_last_r  <= in_tlast;
      end else if (out_free) begin
        a_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    acc = ACC_W'(tap_prod[0]) + ACC_W'(tap_prod[1])
        + ACC_W'(tap_prod[2]) + ACC_W'(tap_prod[3]);
    acc_rnd       = acc + ROUND_ADD;
    haar_soc_sum  = {1'b0, tap_sample[0]} + {1'b0, tap_sample[1]};
    haar_time_sum = {1'b0, tap_time[0]} + {1'b0, tap_time[1]};
    d4_time_sum   = {2'b00, tap_time[0]} + {2'b00, tap_time[1]}
                  + {2'b00, tap_time[2]} + {2'b00, tap_time[3]};
    case (a_kind_r)
      KIND_HAAR: begin
        soc_nxt  = SOC_OUT_W'({haar_soc_sum, 1'b0});
        time_nxt = {haar_time_sum, 1'b0};
      end
      KIND_D4: begin
        soc_nxt  = acc_rnd[ROUND_SHIFT +: SOC_OUT_W];
        time_nxt = d4_time_sum;
      end
      default: begin
        soc_nxt  = SOC_OUT_W'({tap_sample[0], 2'b00});
        time_nxt = {tap_time[0], 2'b00};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && a_valid_r) begin
      out_soc_r  <= soc_nxt;
      out_time_r <= time_nxt;
      out_last_r <= a_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_time_r, out_soc_r});
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_series_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tlast) |=> (pos_r == 2'd0))
    else $error("window not restarted after end of series");

  a_haar_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_HAAR) |-> (pos_r == 2'd0 || pos_r == 2'd1))
    else $error("Haar window position out of range");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && !out_free) |=> (a_valid_r && $stable(a_last_r) && !$past(in_fire)))
    else $error("tap stage changed while stalled");
`endif

endmodule

// File: bench/wld_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wld_checker
// Passive checker for the wavelet low-pass decimator. It follows the mode
// writes and the accepted sample words, predicts every approximation word
// in Haar, Daubechies-2 and passthrough modes, and compares each delivered
// word field by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module wld_checker
  import wld_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [MODE_W-1:0]     cfg_data,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  // soc_sample, sample_time, zero fill
  input  logic [((SAMPLE_BITS_DEF+TIME_BITS_DEF+7)/8)*8-1:0] in_tdata,
  input  logic                  in_tlast,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  // avg_soc, avg_time, zero fill
  input  logic [((SAMPLE_BITS_DEF+TIME_BITS_DEF+6+7)/8)*8-1:0] out_tdata,
  input  logic                  out_tlast,
  output int                    fail_count,
  output int                    pending
);

  localparam int SOC_OUT_W  = SAMPLE_BITS_DEF + 4;
  localparam int TIME_OUT_W = TIME_BITS_DEF + 2;

  localparam longint TAP_OLDEST = 31652;
  localparam longint TAP_OLDER  = 54822;
  localparam longint TAP_NEWER  = 14689;
  localparam longint TAP_NEWEST = -8481;
  localparam longint ROUND_HALF = 8192;
  localparam int     FRAC_SHIFT = 14;

  typedef struct packed {
    logic [SOC_OUT_W-1:0]  soc;
    logic [TIME_OUT_W-1:0] ticks;
    logic                  last;
  } approx_word_t;

  approx_word_t                 approx_q[$];
  logic [MODE_W-1:0]            mode;
  logic [SAMPLE_BITS_DEF-1:0]   soc_hist [3];
  logic [TIME_BITS_DEF-1:0]     time_hist [3];
  logic [1:0]                   win_pos;
  int                           errors;

  task automatic advance_window(input logic [SAMPLE_BITS_DEF-1:0] s,
                                input logic [TIME_BITS_DEF-1:0] t,
                                input logic last,
                                output bit emit,
                                output approx_word_t word);
    longint acc;
    longint tsum;
    emit = 1'b0;
    word = '0;
    acc  = 0;
    tsum = 0;
    case (mode)
      MODE_HAAR: begin
        if (win_pos == 2'd0) begin
          win_pos = 2'd1;
        end else begin
          acc     = (longint'(soc_hist[0]) + longint'(s)) * 2;
          tsum    = (longint'(time_hist[0]) + longint'(t)) * 2;
          emit    = 1'b1;
          win_pos = 2'd0;
        end
      end
      MODE_D4: begin
        if (win_pos == 2'd3) begin
          acc = TAP_OLDEST * longint'(soc_hist[2]) + TAP_OLDER * longint'(soc_hist[1])
              + TAP_NEWER * longint'(soc_hist[0]) + TAP_NEWEST * longint'(s);
          acc  = (acc + ROUND_HALF) >>> FRAC_SHIFT;
          tsum = longint'(time_hist[2]) + longint'(time_hist[1])
               + longint'(time_hist[0]) + longint'(t);
          emit    = 1'b1;
          win_pos = 2'd2;
        end else begin
          win_pos = win_pos + 2'd1;
        end
      end
      default: begin
        acc     = longint'(s) * 4;
        tsum    = longint'(t) * 4;
        emit    = 1'b1;
        win_pos = 2'd0;
      end
    endcase
    word.soc   = acc[SOC_OUT_W-1:0];
    word.ticks = tsum[TIME_OUT_W-1:0];
    word.last  = last;
    soc_hist[2]  = soc_hist[1];
    soc_hist[1]  = soc_hist[0];
    soc_hist[0]  = s;
    time_hist[2] = time_hist[1];
    time_hist[1] = time_hist[0];
    time_hist[0] = t;
    if (last) begin
      win_pos = 2'd0;
    end
  endtask

  task automatic report(input string field, input logic [TIME_OUT_W-1:0] want,
                        input logic [TIME_OUT_W-1:0] got);
    $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
    errors++;
  endtask

  always @(posedge clk) begin
    approx_word_t fresh;
    approx_word_t want;
    approx_word_t got;
    bit           emit;
    if (!rst_n) begin
      mode    = MODE_HAAR;
      win_pos = 2'd0;
      errors  = 0;
      for (int i = 0; i < 3; i++) begin
        soc_hist[i]  = '0;
        time_hist[i] = '0;
      end
      approx_q.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode    = cfg_data;
        win_pos = 2'd0;
      end
      if (in_tvalid && in_tready) begin
        advance_window(in_tdata[SAMPLE_BITS_DEF-1:0],
                       in_tdata[SAMPLE_BITS_DEF+TIME_BITS_DEF-1:SAMPLE_BITS_DEF],
                       in_tlast, emit, fresh);
        if (emit) begin
          approx_q.insert(approx_q.size(), fresh);
        end
      end
      if (out_tvalid && out_tready) begin
        got.soc   = out_tdata[SOC_OUT_W-1:0];
        got.ticks = out_tdata[SOC_OUT_W+TIME_OUT_W-1:SOC_OUT_W];
        got.last  = out_tlast;
        if (approx_q.size() == 0) begin
          $display("%0t ns: unexpected word, expected none, actual %h", $time, got);
          errors++;
        end else begin
          want = approx_q.pop_front();
          if (got.soc !== want.soc) begin
            report("avg_soc", TIME_OUT_W'(want.soc), TIME_OUT_W'(got.soc));
          end
          if (got.ticks !== want.ticks) begin
            report("avg_time", want.ticks, got.ticks);
          end
          if (got.last !== want.last) begin
            report("end_of_series", TIME_OUT_W'(want.last), TIME_OUT_W'(got.last));
          end
        end
      end
      fail_count <= errors;
      pending    <= approx_q.size();
    end
  end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the wavelet low-pass decimator. A directed run
// covers field extremes, every mode, odd and short series, then random
// series with random stalls on both sides, a long output hold-off and
// drain pauses; the checker beside the block scores every result word.
// ----------------------------------------------------------------------------
module tb;
  import wld_pkg::*;

  localparam int IN_W  = ((SAMPLE_BITS_DEF + TIME_BITS_DEF + 7) / 8) * 8;
  localparam int OUT_W = ((SAMPLE_BITS_DEF + TIME_BITS_DEF + 6 + 7) / 8) * 8;

  localparam logic [MODE_W-1:0] MODE_PASS  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  localparam int TARGET_WORDS  = 1050;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 3000;

  localparam logic [15:0] SOC_MAX  = 16'hFFFF;
  localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [MODE_W-1:0] cfg_data = MODE_HAAR;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  // soc_sample, sample_time, zero fill
  logic [IN_W-1:0]   in_tdata = '0;
  logic              in_tlast = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  // avg_soc, avg_time, zero fill
  logic [OUT_W-1:0]  out_tdata;
  logic              out_tlast;
  int                fail_count;
  int                pending;
  bit                steady = 1'b0;
  bit                hold_off = 1'b0;
  int                sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  wavelet_lowpass_decimator u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  wld_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  function automatic int pause_len();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(12, 40);
    end
    return $urandom_range(1, 3);
  endfunction

  task automatic send_sample(input logic [15:0] s, input logic [31:0] t, input logic last);
    in_tdata  <= {t, s};
    in_tlast  <= last;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
    if (!steady && $urandom_range(0, 2) == 0) begin
      in_tvalid <= 1'b0;
      repeat (pause_len()) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_mode(input logic [MODE_W-1:0] m);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_data  <= m;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // The receiver stalls at random, and once for a long stretch on request.
  initial begin
    wait (rst_n);
    forever begin
      if (hold_off) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat (pause_len()) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic [MODE_W-1:0] mode_order [4];
    int                phase;
    int                phase_len;
    int                count;
    int                series_len;
    logic [15:0]       soc;
    logic              last;
    mode_order = '{MODE_HAAR, MODE_D4, MODE_PASS, MODE_SPARE};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Haar from reset: zero and full-scale pairs, then an odd series.
    send_sample(16'h0000, 32'h0000_0000, 1'b0);
    send_sample(16'h0000, 32'h0000_0000, 1'b0);
    send_sample(SOC_MAX, TIME_MAX, 1'b0);
    send_sample(SOC_MAX, TIME_MAX, 1'b1);
    send_sample(16'h1234, 32'h0000_0100, 1'b0);
    send_sample(16'h0005, 32'h0000_0101, 1'b0);
    send_sample(16'h0007, 32'h0000_0102, 1'b1);

    // Daubechies-2: most negative output, a stride, a short series, largest output.
    write_mode(MODE_D4);
    send_sample(16'h0000, 32'h0000_0010, 1'b0);
    send_sample(16'h0000, 32'h0000_0011, 1'b0);
    send_sample(16'h0000, 32'h0000_0012, 1'b0);
    send_sample(SOC_MAX, 32'h0000_0013, 1'b0);
    send_sample(SOC_MAX, 32'h0000_0014, 1'b0);
    send_sample(16'h0000, 32'h0000_0015, 1'b1);
    send_sample(SOC_MAX, TIME_MAX, 1'b0);
    send_sample(SOC_MAX, TIME_MAX, 1'b0);
    send_sample(SOC_MAX, TIME_MAX, 1'b1);
    send_sample(SOC_MAX, TIME_MAX, 1'b0);
    send_sample(SOC_MAX, TIME_MAX, 1'b0);
    send_sample(SOC_MAX, TIME_MAX, 1'b0);
    send_sample(16'h0000, TIME_MAX, 1'b1);

    write_mode(MODE_PASS);
    send_sample(SOC_MAX, TIME_MAX, 1'b0);
    send_sample(16'h0000, 32'h0000_0000, 1'b1);
    write_mode(MODE_SPARE);
    send_sample(16'h8001, 32'h8000_0001, 1'b1);
    send_sample(SOC_MAX, TIME_MAX, 1'b0);

    phase = 0;
    while (sent < TARGET_WORDS) begin
      write_mode(phase < 4 ? mode_order[phase] : mode_order[$urandom_range(0, 3)]);
      steady = (phase % 5 == 3);
      if (phase == 2) begin
        steady   = 1'b1;
        hold_off = 1'b1;
      end
      phase_len = $urandom_range(60, 110);
      count = 0;
      while (count < phase_len) begin
        series_len = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 30)
                                                 : $urandom_range(1, 9);
        for (int k = 0; k < series_len; k++) begin
          case ($urandom_range(0, 7))
            0:       soc = 16'h0000;
            1:       soc = SOC_MAX;
            default: soc = 16'($urandom);
          endcase
          // Mostly clean series, with a few unterminated ones and stray ends.
          last = ((k == series_len - 1) && $urandom_range(0, 7) != 0)
              || ($urandom_range(0, 40) == 0);
          send_sample(soc, $urandom, last);
          count++;
        end
        if ($urandom_range(0, 15) == 0) begin
          drain_results();
        end
      end
      phase++;
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
